/* design/rcsk_pkg.sv */
package rcsk_pkg;

	// Fixed field widths
	localparam int ADC_W      = 12;
	localparam int BTN_W      = 8;
	localparam int TICK_W     = 32;
	localparam int CH_W       = 11;
	localparam int AUX_W      = 4;
	localparam int TRIM_W     = 10;
	localparam int STEP_W     = 6;
	localparam int HOLDOFF_W  = 8;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 10;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 72;
	localparam int NUM_LANES  = 4;

	// Default sample width
	localparam int ADC_BITS_DEF = 12;

	// Channel constants
	localparam int CH_BASE    = 1000;
	localparam int CH_LOW     = 1000;
	localparam int CH_HIGH    = 2000;
	localparam int TRIM_LIMIT = 500;

	// Register reset values
	localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST = 8'd30;
	localparam logic [STEP_W-1:0]    STEP_RST    = 6'd5;

	// Lane order
	localparam int LANE_THROTTLE = 0;
	localparam int LANE_PITCH    = 1;
	localparam int LANE_YAW      = 2;
	localparam int LANE_ROLL     = 3;

	// Button bit positions (active low on the bus)
	localparam int BTN_AUX1  = 0;
	localparam int BTN_AUX2  = 1;
	localparam int BTN_AUX3  = 2;
	localparam int BTN_AUX4  = 3;
	localparam int BTN_LEFT  = 4;
	localparam int BTN_RIGHT = 5;
	localparam int BTN_FRONT = 6;
	localparam int BTN_BACK  = 7;

	// Register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_HOLDOFF    = 2'd0,
		REG_TRIM_STEP  = 2'd1,
		REG_ROLL_TRIM  = 2'd2,
		REG_PITCH_TRIM = 2'd3
	} reg_idx_t;

	// Button machine phases
	typedef enum logic [1:0] {
		PH_HOLDOFF = 2'd0,
		PH_RELEASE = 2'd1,
		PH_ACT     = 2'd2
	} key_phase_t;

	// Buzzer commands
	typedef enum logic [1:0] {
		BEEP_NONE = 2'd0,
		BEEP_LOW  = 2'd1,
		BEEP_HIGH = 2'd2
	} beep_t;

	// Button machine result for one item
	typedef struct packed {
		beep_t                    beep;
		logic                     trim_changed;
		logic signed [TRIM_W-1:0] pitch_trim;
		logic signed [TRIM_W-1:0] roll_trim;
		logic [AUX_W-1:0]         aux;
	} key_res_t;

	// Saturate a trim sum to the legal range
	function automatic logic signed [TRIM_W-1:0] sat_trim(input logic signed [11:0] v);
		logic signed [11:0] lim;
		lim = 12'sd500;
		if (v > lim) begin
			return TRIM_W'(lim);
		end else if (v < -lim) begin
			return TRIM_W'(-lim);
		end
		return v[TRIM_W-1:0];
	endfunction

endpackage

/* design/rcsk_lane.sv */
module rcsk_lane import rcsk_pkg::*; #(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic [ADC_W-1:0]         sample,
	input  logic signed [TRIM_W-1:0] trim,
	output logic [CH_W-1:0]          ch_out
);

	localparam int USED   = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
	localparam int FILT_W = $clog2(CH_BASE + TRIM_LIMIT + (2 ** (USED - 2)));
	localparam int SUM_W  = FILT_W + 2;

	logic [FILT_W-1:0]       filt_q;
	logic [FILT_W-1:0]       filt_d;
	logic [USED-3:0]         quarter;
	logic signed [SUM_W-1:0] raw;
	logic [FILT_W-1:0]       raw_u;
	logic [SUM_W-1:0]        sum;

	// Raw value: base plus quarter sample plus trim, never below 500
	assign quarter = sample[USED-1:2];
	assign raw     = $signed(SUM_W'(CH_BASE)) + $signed(SUM_W'(quarter)) + SUM_W'(trim);
	assign raw_u   = raw[FILT_W-1:0];

	// First-order filter: (raw + 3*prev) / 4
	assign sum    = SUM_W'(raw_u) + SUM_W'(filt_q) + (SUM_W'(filt_q) << 1);
	assign filt_d = sum[SUM_W-1:2];

	// Clamp the new value to the channel range
	always_comb begin
		if (filt_d > FILT_W'(CH_HIGH)) begin
			ch_out = CH_W'(CH_HIGH);
		end else if (filt_d < FILT_W'(CH_LOW)) begin
			ch_out = CH_W'(CH_LOW);
		end else begin
			ch_out = filt_d[CH_W-1:0];
		end
	end

	// Advance the filter state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
		end else if (en) begin
			filt_q <= filt_d;
		end
	end

endmodule

/* design/rcsk_keys.sv */
module rcsk_keys import rcsk_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                     en,
	input  logic [BTN_W-1:0]         buttons_n,
	input  logic [TICK_W-1:0]        tick_now,
	output logic signed [TRIM_W-1:0] roll_trim,
	output logic signed [TRIM_W-1:0] pitch_trim,
	output key_res_t                 res
);

	key_phase_t               phase_q, phase_d;
	logic [TICK_W-1:0]        last_tick_q, last_tick_d;
	logic [AUX_W-1:0]         aux_q, aux_d;
	logic signed [TRIM_W-1:0] roll_trim_q, roll_trim_d;
	logic signed [TRIM_W-1:0] pitch_trim_q, pitch_trim_d;
	logic [HOLDOFF_W-1:0]     holdoff_q;
	logic [STEP_W-1:0]        step_q;
	logic [BTN_W-1:0]         pressed;
	logic [TICK_W-1:0]        elapsed;
	logic signed [11:0]       step_x;
	logic signed [11:0]       roll_x;
	logic signed [11:0]       pitch_x;
	logic signed [11:0]       cfg_trim;
	logic                     changed;
	beep_t                    beep;

	assign pressed  = ~buttons_n;
	assign elapsed  = tick_now - last_tick_q;
	assign step_x   = $signed({6'b0, step_q});
	assign roll_x   = 12'(roll_trim_q);
	assign pitch_x  = 12'(pitch_trim_q);
	assign cfg_trim = 12'($signed(cfg_wdata));

	// Trims seen by the lanes are those held before this item
	assign roll_trim  = roll_trim_q;
	assign pitch_trim = pitch_trim_q;

	// Phase sequencing and button actions
	always_comb begin
		phase_d      = phase_q;
		last_tick_d  = last_tick_q;
		aux_d        = aux_q;
		roll_trim_d  = roll_trim_q;
		pitch_trim_d = pitch_trim_q;
		changed      = 1'b0;
		beep         = BEEP_NONE;
		unique case (phase_q)
			PH_HOLDOFF: begin
				if (elapsed > TICK_W'(holdoff_q)) begin
					beep = BEEP_LOW;
					if (pressed == '0) begin
						phase_d = PH_RELEASE;
					end
				end
			end
			PH_RELEASE: begin
				if (pressed != '0) begin
					phase_d = PH_ACT;
				end
			end
			PH_ACT: begin
				priority if (pressed[BTN_AUX1]) begin
					aux_d[0] = ~aux_q[0];
				end else if (pressed[BTN_AUX2]) begin
					aux_d[1] = ~aux_q[1];
				end else if (pressed[BTN_AUX3]) begin
					aux_d[2] = ~aux_q[2];
				end else if (pressed[BTN_AUX4]) begin
					aux_d[3] = ~aux_q[3];
				end else if (pressed[BTN_LEFT]) begin
					roll_trim_d = sat_trim(roll_x - step_x);
					changed     = 1'b1;
				end else if (pressed[BTN_RIGHT]) begin
					roll_trim_d = sat_trim(roll_x + step_x);
					changed     = 1'b1;
				end else if (pressed[BTN_FRONT]) begin
					pitch_trim_d = sat_trim(pitch_x - step_x);
					changed      = 1'b1;
				end else if (pressed[BTN_BACK]) begin
					pitch_trim_d = sat_trim(pitch_x + step_x);
					changed      = 1'b1;
				end else begin
					// all released again: act on nothing
				end
				phase_d     = PH_HOLDOFF;
				beep        = BEEP_HIGH;
				last_tick_d = tick_now;
			end
			default: begin
				phase_d = PH_HOLDOFF;
			end
		endcase
	end

	// Result as it stands after this item
	always_comb begin
		res.beep         = beep;
		res.trim_changed = changed;
		res.pitch_trim   = pitch_trim_d;
		res.roll_trim    = roll_trim_d;
		res.aux          = aux_d;
	end

	// Hold state; take configuration writes, otherwise advance on each item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HOLDOFF;
			last_tick_q  <= '0;
			aux_q        <= '0;
			roll_trim_q  <= '0;
			pitch_trim_q <= '0;
			holdoff_q    <= HOLDOFF_RST;
			step_q       <= STEP_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_HOLDOFF:    holdoff_q    <= cfg_wdata[HOLDOFF_W-1:0];
				REG_TRIM_STEP:  step_q       <= cfg_wdata[STEP_W-1:0];
				REG_ROLL_TRIM:  roll_trim_q  <= sat_trim(cfg_trim);
				REG_PITCH_TRIM: pitch_trim_q <= sat_trim(cfg_trim);
				default: ;
			endcase
		end else if (en) begin
			phase_q      <= phase_d;
			last_tick_q  <= last_tick_d;
			aux_q        <= aux_d;
			roll_trim_q  <= roll_trim_d;
			pitch_trim_q <= pitch_trim_d;
		end
	end

endmodule

/* design/rcsk_out_buf.sv */
module rcsk_out_buf import rcsk_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [OUT_DATA_W-1:0] in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data
);

	logic                  valid_q;
	logic [OUT_DATA_W-1:0] data_q;
	logic                  skid_valid_q;
	logic [OUT_DATA_W-1:0] skid_data_q;

	// Take a new item whenever the skid slot is free
	assign in_ready  = !skid_valid_q;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// Control: output register with one skid slot behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (valid_q && !out_ready) begin
			if (in_valid && in_ready) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			valid_q      <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	// Payload: park in skid while stalled, else refill the output register
	always_ff @(posedge clk) begin
		if (valid_q && !out_ready) begin
			if (in_valid && in_ready) begin
				skid_data_q <= in_data;
			end
		end else if (skid_valid_q) begin
			data_q <= skid_data_q;
		end else if (in_valid) begin
			data_q <= in_data;
		end
	end

endmodule

/* design/rc_stick_filter_and_key_trim.sv */
// Channel   Ports                                  Content
// s_axis    s_tvalid s_tready s_tdata[87:0]        one frame: sticks, buttons, tick
// m_axis    m_tvalid m_tready m_tdata[71:0]        one result: channels, aux, trims
// cfg       cfg_we cfg_addr[1:0] cfg_wdata[9:0]    register write, no read-back
//
// One item per cycle while the skid slot is free; a frame is computed in the cycle
// it is accepted and its result is registered in the output register or skid slot.
// Reset clears filters, button phase, aux switches and trims; no clearing pass.
// A stalled output parks one further item in a skid slot; s_tready drops only
// when both the output register and the skid slot are full.
module rc_stick_filter_and_key_trim import rcsk_pkg::*; #(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// adc_throttle[11:0], adc_pitch[23:12], adc_yaw[35:24], adc_roll[47:36],
	// buttons_n[55:48], tick_now[87:56]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// throttle_out[10:0], pitch_out[21:11], yaw_out[32:22], roll_out[43:33],
	// aux_mask[47:44], roll_trim_out[57:48], pitch_trim_out[67:58],
	// trim_changed[68], beep_cmd[70:69], zero[71]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic                     accept;
	logic [ADC_W-1:0]         sample [NUM_LANES];
	logic signed [TRIM_W-1:0] lane_trim [NUM_LANES];
	logic [CH_W-1:0]          ch_val [NUM_LANES];
	logic signed [TRIM_W-1:0] roll_trim;
	logic signed [TRIM_W-1:0] pitch_trim;
	key_res_t                 key_res;
	logic [OUT_DATA_W-1:0]    result;

	assign accept = s_tvalid && s_tready;

	// Split the frame into lane samples
	assign sample[LANE_THROTTLE] = s_tdata[11:0];
	assign sample[LANE_PITCH]    = s_tdata[23:12];
	assign sample[LANE_YAW]      = s_tdata[35:24];
	assign sample[LANE_ROLL]     = s_tdata[47:36];

	// Only pitch and roll carry a trim
	assign lane_trim[LANE_THROTTLE] = '0;
	assign lane_trim[LANE_PITCH]    = pitch_trim;
	assign lane_trim[LANE_YAW]      = '0;
	assign lane_trim[LANE_ROLL]     = roll_trim;

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		rcsk_lane #(
			.ADC_BITS(ADC_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (accept),
			.sample (sample[i]),
			.trim   (lane_trim[i]),
			.ch_out (ch_val[i])
		);
	end

	rcsk_keys u_keys (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.en         (accept),
		.buttons_n  (s_tdata[55:48]),
		.tick_now   (s_tdata[87:56]),
		.roll_trim  (roll_trim),
		.pitch_trim (pitch_trim),
		.res        (key_res)
	);

	// Merge lane outputs and button result into one item
	assign result = {1'b0, key_res.beep, key_res.trim_changed, key_res.pitch_trim,
		key_res.roll_trim, key_res.aux, ch_val[LANE_ROLL], ch_val[LANE_YAW],
		ch_val[LANE_PITCH], ch_val[LANE_THROTTLE]};

	rcsk_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (result),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

/* tb/sv/tb_rc_stick_filter_and_key_trim.sv */
module tb_rc_stick_filter_and_key_trim;
	timeunit 1ns;
	timeprecision 1ps;

	import rcsk_pkg::*;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int MAX_REPORTS     = 10;
	localparam int ITEMS_PER_PHASE = 245;
	localparam int DRAIN_CYCLES    = 4;
	localparam logic [BTN_W-1:0] ALL_RELEASED = '1;

	// One input item, last field in the lowest bits
	typedef struct packed {
		logic [TICK_W-1:0] tick_now;
		logic [BTN_W-1:0]  buttons_n;
		logic [ADC_W-1:0]  adc_roll;
		logic [ADC_W-1:0]  adc_yaw;
		logic [ADC_W-1:0]  adc_pitch;
		logic [ADC_W-1:0]  adc_throttle;
	} stick_frame_t;

	// One result item, last field in the lowest bits
	typedef struct packed {
		logic              zero;
		beep_t             beep_cmd;
		logic              trim_changed;
		logic [TRIM_W-1:0] pitch_trim_out;
		logic [TRIM_W-1:0] roll_trim_out;
		logic [AUX_W-1:0]  aux_mask;
		logic [CH_W-1:0]   roll_out;
		logic [CH_W-1:0]   yaw_out;
		logic [CH_W-1:0]   pitch_out;
		logic [CH_W-1:0]   throttle_out;
	} channel_set_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	// adc_throttle, adc_pitch, adc_yaw, adc_roll, buttons_n, tick_now
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	// throttle_out, pitch_out, yaw_out, roll_out, aux_mask, roll_trim_out,
	// pitch_trim_out, trim_changed, beep_cmd, zero
	logic [OUT_DATA_W-1:0] m_tdata;

	// Shadow copy of the block's state and registers
	logic [11:0]              filt_q [NUM_LANES];
	key_phase_t               phase_q;
	logic [TICK_W-1:0]        last_tick_q;
	logic [AUX_W-1:0]         aux_q;
	logic signed [10:0]       roll_trim_q;
	logic signed [10:0]       pitch_trim_q;
	logic [HOLDOFF_W-1:0]     holdoff_q;
	logic [STEP_W-1:0]        step_q;

	channel_set_t             predicted_outputs [$];

	// Stick sample pattern of the current run of items
	bit                       stick_fixed [NUM_LANES];
	logic [ADC_W-1:0]         stick_base [NUM_LANES];

	int                       frames_sent;
	int                       results_checked;
	int                       failures;
	int                       idle_cycles;
	int                       sender_quiet;

	rc_stick_filter_and_key_trim u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int clip_trim(input int v);
		if (v > TRIM_LIMIT) return TRIM_LIMIT;
		if (v < -TRIM_LIMIT) return -TRIM_LIMIT;
		return v;
	endfunction

	// Advance one lane's smoothing filter and clamp its output
	function automatic logic [CH_W-1:0] smooth_channel(input int lane,
			input logic [ADC_W-1:0] sample, input int trim);
		int raw;
		int acc;
		raw = CH_BASE + int'(sample >> 2) + trim;
		acc = (raw + 3 * int'(filt_q[lane])) >> 2;
		filt_q[lane] = acc[11:0];
		if (acc > CH_HIGH) return CH_W'(CH_HIGH);
		if (acc < CH_LOW) return CH_W'(CH_LOW);
		return acc[CH_W-1:0];
	endfunction

	// Work out the channels and button actions caused by one frame
	function automatic channel_set_t condition_frame(input stick_frame_t f);
		channel_set_t r;
		logic [BTN_W-1:0] pressed;
		logic [TICK_W-1:0] since;
		int step;
		r = '0;
		pressed = ~f.buttons_n;
		since = f.tick_now - last_tick_q;
		step = int'(step_q);
		// sticks use the trims held before this frame
		r.throttle_out = smooth_channel(LANE_THROTTLE, f.adc_throttle, 0);
		r.pitch_out    = smooth_channel(LANE_PITCH, f.adc_pitch, int'(pitch_trim_q));
		r.yaw_out      = smooth_channel(LANE_YAW, f.adc_yaw, 0);
		r.roll_out     = smooth_channel(LANE_ROLL, f.adc_roll, int'(roll_trim_q));
		r.beep_cmd     = BEEP_NONE;
		case (phase_q)
			PH_HOLDOFF: begin
				if (since > holdoff_q) begin
					if (pressed == '0) phase_q = PH_RELEASE;
					r.beep_cmd = BEEP_LOW;
				end
			end
			PH_RELEASE: begin
				if (pressed != '0) phase_q = PH_ACT;
			end
			PH_ACT: begin
				if (pressed[BTN_AUX1]) aux_q[BTN_AUX1] = ~aux_q[BTN_AUX1];
				else if (pressed[BTN_AUX2]) aux_q[BTN_AUX2] = ~aux_q[BTN_AUX2];
				else if (pressed[BTN_AUX3]) aux_q[BTN_AUX3] = ~aux_q[BTN_AUX3];
				else if (pressed[BTN_AUX4]) aux_q[BTN_AUX4] = ~aux_q[BTN_AUX4];
				else if (pressed[BTN_LEFT]) begin
					roll_trim_q = 11'(clip_trim(int'(roll_trim_q) - step));
					r.trim_changed = 1'b1;
				end else if (pressed[BTN_RIGHT]) begin
					roll_trim_q = 11'(clip_trim(int'(roll_trim_q) + step));
					r.trim_changed = 1'b1;
				end else if (pressed[BTN_FRONT]) begin
					pitch_trim_q = 11'(clip_trim(int'(pitch_trim_q) - step));
					r.trim_changed = 1'b1;
				end else if (pressed[BTN_BACK]) begin
					pitch_trim_q = 11'(clip_trim(int'(pitch_trim_q) + step));
					r.trim_changed = 1'b1;
				end
				phase_q = PH_HOLDOFF;
				r.beep_cmd = BEEP_HIGH;
				last_tick_q = f.tick_now;
			end
			default: begin
				phase_q = PH_HOLDOFF;
			end
		endcase
		r.aux_mask       = aux_q;
		r.roll_trim_out  = roll_trim_q[TRIM_W-1:0];
		r.pitch_trim_out = pitch_trim_q[TRIM_W-1:0];
		return r;
	endfunction

	// Mostly short gaps, a few long ones, now and then a stretch with none
	function automatic int pick_gap(ref int quiet);
		int r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			quiet = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void hold_sticks(input logic [ADC_W-1:0] v);
		foreach (stick_fixed[i]) begin
			stick_fixed[i] = 1'b1;
			stick_base[i]  = v;
		end
	endfunction

	// Per lane: uniform noise, or a held value at either end or in between
	function automatic void pick_sticks();
		int r;
		foreach (stick_fixed[i]) begin
			r = $urandom_range(0, 5);
			stick_fixed[i] = (r >= 3);
			case (r)
				3: stick_base[i] = '0;
				4: stick_base[i] = '1;
				default: stick_base[i] = ADC_W'($urandom);
			endcase
		end
	endfunction

	function automatic logic [ADC_W-1:0] next_sample(input int lane);
		return stick_fixed[lane] ? stick_base[lane] : ADC_W'($urandom);
	endfunction

	// Offer one frame after a random gap and hold it until it is taken
	task automatic send_frame(input logic [BTN_W-1:0] buttons_n, input logic [TICK_W-1:0] tick);
		stick_frame_t f;
		int gap;
		f.adc_throttle = next_sample(LANE_THROTTLE);
		f.adc_pitch    = next_sample(LANE_PITCH);
		f.adc_yaw      = next_sample(LANE_YAW);
		f.adc_roll     = next_sample(LANE_ROLL);
		f.buttons_n    = buttons_n;
		f.tick_now     = tick;
		gap = pick_gap(sender_quiet);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= f;
		do @(posedge clk); while (!s_tready);
		predicted_outputs.push_back(condition_frame(f));
		frames_sent++;
	endtask

	// Hold the sender until every pending result is out
	task automatic drain_outputs();
		s_tvalid <= 1'b0;
		while (predicted_outputs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_HOLDOFF:    holdoff_q = val[HOLDOFF_W-1:0];
			REG_TRIM_STEP:  step_q = val[STEP_W-1:0];
			REG_ROLL_TRIM:  roll_trim_q = 11'(clip_trim(int'($signed(val))));
			REG_PITCH_TRIM: pitch_trim_q = 11'(clip_trim(int'($signed(val))));
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] hold, step, roll, pitch);
		write_reg(REG_HOLDOFF, hold);
		write_reg(REG_TRIM_STEP, step);
		write_reg(REG_ROLL_TRIM, roll);
		write_reg(REG_PITCH_TRIM, pitch);
		cfg_we <= 1'b0;
	endtask

	// Arm, press, then act on the pressed button or on a release
	task automatic run_key_action(input logic [BTN_W-1:0] press_mask, input bit release_on_act,
			inout logic [TICK_W-1:0] tick);
		send_frame(ALL_RELEASED, tick);
		send_frame(~press_mask, tick + 1);
		send_frame(release_on_act ? ALL_RELEASED : ~press_mask, tick + 2);
		tick += 3;
	endtask

	task automatic note_failure(input string what);
		if (failures < MAX_REPORTS) $display("%s", what);
		failures++;
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want)
			note_failure($sformatf("result %0d %s: expected %0d, got %0d",
				results_checked, name, want, got));
	endtask

	// Filter from zero with the reset hold-off: no beep, then armed
	task automatic test_reset_defaults();
		hold_sticks('0);
		send_frame(ALL_RELEASED, 32'd5);
		hold_sticks('1);
		send_frame(ALL_RELEASED, 32'd31);
		send_frame(ALL_RELEASED, 32'd33);
	endtask

	// Every button once, trims saturating, tick wrapping through zero
	task automatic test_button_actions();
		logic [TICK_W-1:0] tick;
		drain_outputs();
		program_regs(10'd0, 10'd63, 10'h1FF, 10'h200);
		tick = 32'hFFFF_FFF8;
		hold_sticks('1);
		run_key_action(BTN_W'(1) << BTN_AUX1, 1'b0, tick);
		run_key_action(BTN_W'(1) << BTN_AUX2, 1'b0, tick);
		run_key_action(BTN_W'(1) << BTN_AUX3, 1'b0, tick);
		run_key_action(BTN_W'(1) << BTN_AUX4, 1'b0, tick);
		run_key_action(BTN_W'(1) << BTN_RIGHT, 1'b0, tick);
		run_key_action(BTN_W'(1) << BTN_LEFT, 1'b0, tick);
		run_key_action(BTN_W'(1) << BTN_FRONT, 1'b0, tick);
		run_key_action(BTN_W'(1) << BTN_BACK, 1'b0, tick);
		hold_sticks('0);
		run_key_action(BTN_W'(1) << BTN_AUX1, 1'b1, tick);
	endtask

	// Well-formed release and press runs with random content, plus noise
	task automatic run_random_phase(input logic [CFG_DATA_W-1:0] hold, step, roll, pitch);
		logic [TICK_W-1:0] tick;
		logic [BTN_W-1:0] pick;
		int first;
		drain_outputs();
		program_regs(hold, step, roll, pitch);
		tick = $urandom;
		first = frames_sent;
		while (frames_sent - first < ITEMS_PER_PHASE) begin
			pick_sticks();
			if ($urandom_range(0, 99) < 85) begin
				tick += $urandom_range(holdoff_q / 2, 2 * holdoff_q + 2);
				repeat ($urandom_range(1, 3)) begin
					send_frame(ALL_RELEASED, tick);
					tick += $urandom_range(0, 3);
				end
				pick = ($urandom_range(0, 3) != 0) ? BTN_W'(1) << $urandom_range(0, BTN_W - 1)
					: BTN_W'($urandom_range(1, 255));
				repeat ($urandom_range(1, 3)) begin
					send_frame(~pick, tick);
					tick += $urandom_range(0, 3);
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					tick = ($urandom_range(0, 3) == 0) ? TICK_W'($urandom)
						: tick + $urandom_range(0, 300);
					send_frame(BTN_W'($urandom), tick);
				end
			end
		end
	endtask

	// Several register settings, extremes among them
	task automatic test_random_settings();
		run_random_phase(10'd30, 10'd5, 10'd0, 10'd0);
		run_random_phase({2'b11, 8'd0}, {4'b1010, 6'd1}, 10'd500, 10'(-500));
		run_random_phase(10'd255, 10'd63, 10'h200, 10'h1FF);
		run_random_phase(10'($urandom), 10'd0, 10'(-500), 10'd500);
		run_random_phase(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
		run_random_phase(10'($urandom_range(0, 40)), 10'd50, 10'd500, 10'(-500));
	endtask

	// Drive the receiver's stalls and check each result taken
	initial begin : result_check
		int stall_left;
		int quiet;
		int gap;
		channel_set_t got;
		channel_set_t want;
		stall_left = 0;
		quiet = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (predicted_outputs.size() == 0) begin
					note_failure($sformatf("result %0d arrived with none pending",
						results_checked));
				end else begin
					want = predicted_outputs.pop_front();
					compare_field("throttle_out", got.throttle_out, want.throttle_out);
					compare_field("pitch_out", got.pitch_out, want.pitch_out);
					compare_field("yaw_out", got.yaw_out, want.yaw_out);
					compare_field("roll_out", got.roll_out, want.roll_out);
					compare_field("aux_mask", got.aux_mask, want.aux_mask);
					compare_field("roll_trim_out", $signed(got.roll_trim_out),
						$signed(want.roll_trim_out));
					compare_field("pitch_trim_out", $signed(got.pitch_trim_out),
						$signed(want.pitch_trim_out));
					compare_field("trim_changed", got.trim_changed, want.trim_changed);
					compare_field("beep_cmd", int'(got.beep_cmd), int'(want.beep_cmd));
					compare_field("zero", got.zero, want.zero);
				end
				results_checked++;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				gap = pick_gap(quiet);
				m_tready <= (gap == 0);
				stall_left = (gap > 0) ? gap - 1 : 0;
			end
		end
	end

	// End the run when nothing has moved for too long
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_addr  <= REG_HOLDOFF;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		// shadow state at reset
		foreach (filt_q[i]) filt_q[i] = '0;
		phase_q         = PH_HOLDOFF;
		last_tick_q     = '0;
		aux_q           = '0;
		roll_trim_q     = '0;
		pitch_trim_q    = '0;
		holdoff_q       = HOLDOFF_RST;
		step_q          = STEP_RST;
		frames_sent     = 0;
		results_checked = 0;
		failures        = 0;
		idle_cycles     = 0;
		sender_quiet    = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_button_actions();
		test_random_settings();
		drain_outputs();
		if (failures == 0 && predicted_outputs.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
